// ===== rtl/tdt_pkg.sv =====
// Shared types and constants for the time-window dedup table.
package tdt_pkg;

    localparam int ADDR_W       = 48;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 16;
    localparam int WIN_SEC_W    = 16;
    // The largest window, 65535 s, is 65535000 ms, which fits in 26 bits.
    localparam int WIN_MS_W     = 26;
    localparam int IDX_W        = 8;
    localparam int MS_PER_SEC   = 1000;
    localparam int WINDOW_RESET = 60;

    // Search token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic              hit;
        logic              accept;
        logic              best_vld;
        logic [TIME_W-1:0] best_time;
        logic [IDX_W-1:0]  best_idx;
    } t_tok;

    // Write command sent to every cell at once.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] time_ms;
    } t_wr;

endpackage

// ===== rtl/tdt_cell.sv =====
// One table entry with its share of the search: match, refresh and oldest tracking.
module tdt_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdt_pkg::t_tok                 i_tok,
    output tdt_pkg::t_tok                 o_tok,
    input  logic [tdt_pkg::IDX_W-1:0]     i_fill,
    input  tdt_pkg::t_wr                  i_wr,
    input  logic [tdt_pkg::WIN_MS_W-1:0]  i_win_limit
);
    import tdt_pkg::*;

    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_time;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              occ;
    logic              match;
    logic [TIME_W-1:0] elapsed;

    // An entry is in use when its index lies below the fill count.
    assign occ     = IDX_W'(IDX) < i_fill;
    assign match   = i_tok.valid && occ && !i_tok.hit && (r_addr == i_tok.addr);
    assign elapsed = i_tok.now - r_time;

    always_comb begin
        n_tok = i_tok;
        if (match) begin
            n_tok.hit    = 1'b1;
            n_tok.accept = elapsed >= {{(TIME_W-WIN_MS_W){1'b0}}, i_win_limit};
        end
        // Strict less-than keeps the lowest index on equal times.
        if (i_tok.valid && occ && (!i_tok.best_vld || r_time < i_tok.best_time)) begin
            n_tok.best_vld  = 1'b1;
            n_tok.best_time = r_time;
            n_tok.best_idx  = IDX_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == IDX_W'(IDX)) begin
            r_addr <= i_wr.addr;
            r_time <= i_wr.time_ms;
        end else if (match) begin
            r_time <= i_tok.now;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/timed_dedup_table_oldest_evict_top.sv =====
// Top level of the time-window dedup table: a row of entry cells and a small controller.
// An accepted item's search token steps through the row of MAP_SIZE cells one cell per
// clock; the outcome at the end of the row is captured and the result is registered out.
// One item at a time: a new item is taken only in S_IDLE, so an output stall holds it off.
// Reset (synchronous, active low) clears the fill count, the unique counter, all control
// state and sets the window to 60 s; the entry contents are left as they are.
module timed_dedup_table_oldest_evict_top #(
    parameter int MAP_SIZE = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tdt_pkg::ADDR_W-1:0]     i_station_addr,
    input  logic [tdt_pkg::TIME_W-1:0]     i_now_ms,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_accept,
    output logic                           o_was_hit,
    output logic [tdt_pkg::CNT_W-1:0]      o_unique_total,
    input  logic                           i_cfg_we,
    input  logic [tdt_pkg::WIN_SEC_W-1:0]  i_cfg_wdata
);
    import tdt_pkg::*;

    // Controller states: waiting for an item, token walking the row, result pending.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [WIN_MS_W-1:0] r_win_limit;
    logic [IDX_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_unique;
    logic               r_hit;
    logic               r_acc;
    logic [IDX_W-1:0]   r_best_idx;
    logic [ADDR_W-1:0]  r_addr;
    logic [TIME_W-1:0]  r_now;
    logic               r_out_valid;
    logic               r_out_accept;
    logic               r_out_hit;
    logic [CNT_W-1:0]   r_out_unique;

    t_tok               tok [MAP_SIZE+1];
    t_tok               head_tok;
    t_wr                wr;
    logic               in_take;
    logic               out_free;
    logic               finish;
    logic               full;
    t_tok               last;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign finish   = (r_state == S_RESULT) && out_free;
    assign full     = r_fill == IDX_W'(MAP_SIZE);
    assign last     = tok[MAP_SIZE];

    // The search token enters the first cell in the cycle the item is accepted.
    always_comb begin
        head_tok       = '0;
        head_tok.valid = in_take;
        head_tok.addr  = i_station_addr;
        head_tok.now   = i_now_ms;
    end

    assign tok[0] = head_tok;

    for (genvar k = 0; k < MAP_SIZE; k++) begin : g_cell
        tdt_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[k]),
            .o_tok       (tok[k+1]),
            .i_fill      (r_fill),
            .i_wr        (wr),
            .i_win_limit (r_win_limit)
        );
    end

    // A miss writes the next free slot, or the oldest entry once the table is full.
    always_comb begin
        wr.en      = finish && !r_hit;
        wr.idx     = full ? r_best_idx : r_fill;
        wr.addr    = r_addr;
        wr.time_ms = r_now;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_take) n_state = S_SCAN;
            S_SCAN:   if (last.valid) n_state = S_RESULT;
            S_RESULT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_limit <= WIN_MS_W'(WINDOW_RESET * MS_PER_SEC);
            r_fill      <= '0;
            r_unique    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // The window is kept in milliseconds so the cells compare directly.
            if (i_cfg_we) begin
                r_win_limit <= WIN_MS_W'(i_cfg_wdata) * WIN_MS_W'(MS_PER_SEC);
            end
            if (wr.en) begin
                r_unique <= r_unique + 1'b1;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload capture: the item at accept, the search outcome at the end of the row.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr <= i_station_addr;
            r_now  <= i_now_ms;
        end
        if (r_state == S_SCAN && last.valid) begin
            r_hit      <= last.hit;
            r_acc      <= last.accept;
            r_best_idx <= last.best_idx;
        end
        if (finish) begin
            r_out_accept <= r_hit ? r_acc : 1'b1;
            r_out_hit    <= r_hit;
            r_out_unique <= r_hit ? r_unique : r_unique + 1'b1;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_accept       = r_out_accept;
    assign o_was_hit      = r_out_hit;
    assign o_unique_total = r_out_unique;

    // The token only leaves the row while the controller is scanning.
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last.valid |-> (r_state == S_SCAN))
        else $error("search token left the row outside of a scan");

    // The fill count never passes the table size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IDX_W'(MAP_SIZE))
        else $error("fill count exceeds table size");

    // A new address is always accepted.
    a_miss_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_was_hit) |-> o_accept)
        else $error("miss result not accepted");

    // An accepted item starts a scan in the next cycle.
    a_take_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

endmodule
